[rtl/sinh_taylor_series_defines.svh]
// Assertion macros shared by the sinh Taylor series RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SINH_TAYLOR_SERIES_DEFINES_SVH
`define SINH_TAYLOR_SERIES_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SINH_TS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SINH_TS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sinh_ts_pkg.sv]
// Package for the sinh Taylor series block: widths, microcode ROM, reciprocal table.
// No dependencies.
`default_nettype none

package sinh_ts_pkg;

  localparam int unsigned ArgW   = 16;  // Q4.12 argument
  localparam int unsigned ValW   = 32;  // Q11.20 result
  localparam int unsigned TermW  = 48;  // Q.32 term and sum magnitude
  localparam int unsigned MagW   = 36;  // sum rounded to Q.20
  localparam int unsigned MulBW  = 16;  // second multiplier operand
  localparam int unsigned ProdW  = TermW + MulBW;
  localparam int unsigned CountW = 5;   // term_count and k
  localparam int unsigned UpcW   = 3;
  localparam int unsigned ProgLen = 2**UpcW;
  localparam int unsigned AddrW  = 3;

  localparam logic [CountW-1:0] TermCountRst = CountW'(31);

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MUL_M_ACC,
    OP_MUL_M,
    OP_MUL_RL,
    OP_MUL_RH,
    OP_ACC,
    OP_ROUND,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_START,  // skip the loop when no steps
    COND_LOOP,   // back to the term start while k < steps
    COND_JUMP
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [UpcW-1:0]   target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic fire;
  } ctrl_t;

  typedef struct packed {
    logic last;
  } status_t;

  // microcode entry points
  localparam logic [UpcW-1:0] UaLoad = UpcW'(0);
  localparam logic [UpcW-1:0] UaTerm = UpcW'(1);
  localparam logic [UpcW-1:0] UaAcc  = UpcW'(5);

  localparam uword_t Ucode [ProgLen] = '{
    '{OP_LOAD,      COND_START, UaAcc},
    '{OP_MUL_M_ACC, COND_NEXT,  UaLoad},
    '{OP_MUL_M,     COND_NEXT,  UaLoad},
    '{OP_MUL_RL,    COND_NEXT,  UaLoad},
    '{OP_MUL_RH,    COND_LOOP,  UaTerm},
    '{OP_ACC,       COND_NEXT,  UaLoad},
    '{OP_ROUND,     COND_NEXT,  UaLoad},
    '{OP_EMIT,      COND_JUMP,  UaLoad}
  };

  // round(2^32 / ((2k+1)(2k))), Q0.32; entry 0 unused
  localparam logic [31:0] Recip [2**CountW] = '{
    32'd0,         32'd715827883, 32'd214748365, 32'd102261126,
    32'd59652324,  32'd39045157,  32'd27531842,  32'd20452225,
    32'd15790321,  32'd12558384,  32'd10226113,  32'd8488078,
    32'd7158279,   32'd6118187,   32'd5289369,   32'd4618244,
    32'd4067204,   32'd3609216,   32'd3224450,   32'd2898089,
    32'd2618882,   32'd2378166,   32'd2169175,   32'd1986571,
    32'd1826092,   32'd1684301,   32'd1558406,   32'd1446117,
    32'd1345541,   32'd1255104,   32'd1173488,   32'd1099582
  };

endpackage

`default_nettype wire

[rtl/sinh_ts_dp.sv]
// Datapath of the sinh Taylor series block: shared 48x16 multiplier, term, sum.
// Depends on sinh_ts_pkg; driven by the microcode sequencer in the top level.
`default_nettype none

module sinh_ts_dp import sinh_ts_pkg::*; (
  input  wire logic                     clk_i,
  input  wire ctrl_t                    ctrl_i,
  input  wire logic signed [ArgW-1:0]   argument_i,
  input  wire logic [CountW-1:0]        steps_i,
  output      status_t                  status_o,
  output      logic [ValW-1:0]          sinh_value_o,
  output      logic                     saturated_o
);

  logic [MulBW-1:0]  m_q, m_d;
  logic              neg_q, neg_d;
  logic [TermW-1:0]  t_q, t_d;
  logic [TermW-1:0]  sum_q, sum_d;
  logic [TermW-1:0]  p_q, p_d;
  logic [MagW-1:0]   mag_q, mag_d;
  logic [CountW-1:0] k_q, k_d;
  logic [CountW-1:0] steps_q, steps_d;

  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  prod;
  logic [31:0]       recip;
  logic [MagW-1:0]   limit;
  logic [MagW-1:0]   clipped;
  logic [ValW-1:0]   low_val;

  assign recip = Recip[k_q];

  always_comb begin
    unique case (ctrl_i.op)
      OP_MUL_RL: mul_b = recip[15:0];
      OP_MUL_RH: mul_b = recip[31:16];
      default:   mul_b = m_q;
    endcase
  end

  assign prod = {{MulBW{1'b0}}, t_q} * {{TermW{1'b0}}, mul_b};

  always_comb begin
    m_d     = m_q;
    neg_d   = neg_q;
    t_d     = t_q;
    sum_d   = sum_q;
    p_d     = p_q;
    mag_d   = mag_q;
    k_d     = k_q;
    steps_d = steps_q;
    if (ctrl_i.fire) begin
      unique case (ctrl_i.op)
        OP_LOAD: begin
          neg_d   = argument_i[ArgW-1];
          m_d     = argument_i[ArgW-1] ? MulBW'(~argument_i + 1'b1) : MulBW'(argument_i);
          t_d     = {{(TermW-MulBW-20){1'b0}}, m_d, 20'd0};
          sum_d   = '0;
          k_d     = CountW'(1);
          steps_d = steps_i;
        end
        OP_MUL_M_ACC: begin
          sum_d = sum_q + t_q;
          t_d   = TermW'((prod + ProdW'(12'h800)) >> 12);
        end
        OP_MUL_M: t_d = TermW'((prod + ProdW'(12'h800)) >> 12);
        OP_MUL_RL: p_d = TermW'(prod >> 16);
        OP_MUL_RH: begin
          // (t*R + 2^31) >> 32 from the two 16-bit halves of R
          t_d = TermW'((prod + {{MulBW{1'b0}}, p_q} + ProdW'(16'h8000)) >> 16);
          k_d = CountW'(k_q + 1'b1);
        end
        OP_ACC:   sum_d = sum_q + t_q;
        OP_ROUND: mag_d = MagW'((sum_q + TermW'(12'h800)) >> 12);
        OP_EMIT:  ;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    neg_q   <= neg_d;
    t_q     <= t_d;
    sum_q   <= sum_d;
    p_q     <= p_d;
    mag_q   <= mag_d;
    k_q     <= k_d;
    steps_q <= steps_d;
  end

  assign status_o.last = (k_q == steps_q);

  // saturate and apply the sign
  assign limit        = neg_q ? MagW'(36'h80000000) : MagW'(36'h7FFFFFFF);
  assign saturated_o  = (mag_q > limit);
  assign clipped      = saturated_o ? limit : mag_q;
  assign low_val      = clipped[ValW-1:0];
  assign sinh_value_o = neg_q ? ValW'(~low_val + 1'b1) : low_val;

endmodule

`default_nettype wire

[rtl/sinh_taylor_series.sv]
// sinh(x) by truncated Taylor series, signed Q4.12 in, signed Q11.20 out (saturating).
// Terms summed: n + 1, n = min(term_count, MAX_TERMS-1). One argument at a time: the next one
// is taken only at the load step, after the previous result is emitted. Each term costs four
// passes through the one shared 48x16 multiplier (two by |x|, two by the reciprocal halves).
// Reset (rst_ni low, async): sequencer at load step, no result pending, term_count = 31.
`default_nettype none

`include "sinh_taylor_series_defines.svh"

module sinh_taylor_series import sinh_ts_pkg::*; #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // argument channel
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic signed [ArgW-1:0]  argument_i,
  // result channel
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic signed [ValW-1:0]  sinh_value_o,
  output      logic                    saturated_o,
  // APB-style config port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [AddrW-1:0]        paddr,
  input  wire logic [31:0]             pwdata,
  output      logic [31:0]             prdata,
  output      logic                    pready
);

  // step cap: at most MAX_TERMS terms summed, k never needs more than CountW bits
  localparam int unsigned StepCap = MAX_TERMS - 1;
  localparam logic [CountW-1:0] StepLim =
      (StepCap > (2**CountW - 1)) ? {CountW{1'b1}} : CountW'(StepCap);

  // register index is the word address
  localparam logic RegTermCount = 1'b0;

  logic [CountW-1:0] term_count_q;
  logic [CountW-1:0] steps;
  logic              cfg_wr;

  logic [UpcW-1:0]   upc_q, upc_d;
  uword_t            uword;
  ctrl_t             ctrl;
  status_t           status;

  logic              out_valid_q, out_valid_d;
  logic [ValW-1:0]   sinh_value_q;
  logic              saturated_q;
  logic [ValW-1:0]   dp_value;
  logic              dp_sat;
  logic              emit;

  // ---------------------------------------------------------------------------
  // Config port: one register, pready tied high. Writes elsewhere are dropped.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegTermCount);
  assign prdata = (paddr[2] == RegTermCount) ? {{(32-CountW){1'b0}}, term_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TermCountRst;
    end else if (cfg_wr) begin
      term_count_q <= pwdata[CountW-1:0];
    end
  end

  assign steps = (term_count_q > StepLim) ? StepLim : term_count_q;

  // ---------------------------------------------------------------------------
  // Microcode sequencer. One ROM word per step; a step only advances when it
  // fires. The load step waits for an input beat, the emit step for a free
  // output register, every other step fires at once.
  // ---------------------------------------------------------------------------
  assign uword      = Ucode[upc_q];
  assign in_ready_o = (uword.op == OP_LOAD);
  assign emit       = (uword.op == OP_EMIT) && ctrl.fire;

  always_comb begin
    unique case (uword.op)
      OP_LOAD: ctrl.fire = in_valid_i;
      OP_EMIT: ctrl.fire = !out_valid_q || out_ready_i;
      default: ctrl.fire = 1'b1;
    endcase
    ctrl.op = uword.op;
  end

  always_comb begin
    upc_d = upc_q;
    if (ctrl.fire) begin
      unique case (uword.cond)
        COND_NEXT:  upc_d = UpcW'(upc_q + 1'b1);
        COND_START: upc_d = (steps == '0) ? uword.target : UpcW'(upc_q + 1'b1);
        COND_LOOP:  upc_d = status.last ? UpcW'(upc_q + 1'b1) : uword.target;
        COND_JUMP:  upc_d = uword.target;
        default:    upc_d = uword.target;
      endcase
    end
  end

  // output register: the next argument can be taken while a result waits here
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UaLoad;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sinh_value_q <= dp_value;
      saturated_q  <= dp_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sinh_value_o = sinh_value_q;
  assign saturated_o  = saturated_q;

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  sinh_ts_dp u_dp (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .argument_i   (argument_i),
    .steps_i      (steps),
    .status_o     (status),
    .sinh_value_o (dp_value),
    .saturated_o  (dp_sat)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SINH_TS_ASSERT_NXT(a_busy_after_beat, in_valid_i && in_ready_o, !in_ready_o,
                      "sequencer did not leave the load step after an input beat")
  `SINH_TS_ASSERT_NXT(a_emit_sets_valid, emit, out_valid_o,
                      "emit step did not present a result")
  `SINH_TS_ASSERT_IMP(a_sat_at_limit, out_valid_o && saturated_o,
                      sinh_value_o == 32'sh7FFFFFFF || sinh_value_o == 32'sh80000000,
                      "saturated result is not a range limit")

endmodule

`default_nettype wire
